>>> design/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg
// Shared types, constants and the header byte function of the BMP serializer.
// ----------------------------------------------------------------------------
package bfs_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = 13;   // register / dimension width
  localparam int CNT_W         = 12;   // column and row counters
  localparam int SIZE_W        = 27;   // file size in bytes
  localparam int IDX_W         = 6;    // byte position within one pixel's run
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam int FILE_HDR_BYTES = 14;
  localparam int INFO_HDR_BYTES = 40;
  localparam int HDR_BYTES      = FILE_HDR_BYTES + INFO_HDR_BYTES;
  localparam int BITS_PER_PIXEL = 24;

  // byte positions within a run
  localparam logic [IDX_W-1:0] POS_SIG_B  = 6'd0;
  localparam logic [IDX_W-1:0] POS_SIG_M  = 6'd1;
  localparam logic [IDX_W-1:0] POS_WORDS  = 6'd2;
  localparam logic [IDX_W-1:0] POS_PLANES = 6'd26;
  localparam logic [IDX_W-1:0] POS_BPP    = 6'd28;
  localparam logic [IDX_W-1:0] POS_WEND   = 6'd26;
  localparam logic [IDX_W-1:0] POS_BLUE   = IDX_W'(HDR_BYTES);
  localparam logic [IDX_W-1:0] POS_GREEN  = IDX_W'(HDR_BYTES + 1);
  localparam logic [IDX_W-1:0] POS_RED    = IDX_W'(HDR_BYTES + 2);

  // header word slots (after the signature)
  localparam logic [3:0] WD_SIZE   = 4'd0;
  localparam logic [3:0] WD_RSVD   = 4'd1;
  localparam logic [3:0] WD_OFFSET = 4'd2;
  localparam logic [3:0] WD_INFO   = 4'd3;
  localparam logic [3:0] WD_WIDTH  = 4'd4;
  localparam logic [3:0] WD_HEIGHT = 4'd5;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [1:0]        pad;
    logic [SIZE_W-1:0] size;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hdr;
    logic [1:0] pad;
    logic       image_end;
  } entry_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx, input cfg_t cfg);
    logic [IDX_W-1:0] k;
    logic [31:0]      word;
    logic [7:0]       b;
    k = idx - POS_WORDS;
    case (k[5:2])
      WD_SIZE:   word = 32'(cfg.size);
      WD_RSVD:   word = '0;
      WD_OFFSET: word = 32'(HDR_BYTES);
      WD_INFO:   word = 32'(INFO_HDR_BYTES);
      WD_WIDTH:  word = 32'(cfg.w);
      WD_HEIGHT: word = 32'(cfg.h);
      default:   word = '0;
    endcase
    b = 8'(word >> {k[1:0], 3'b000});
    if (idx == POS_SIG_B)       b = 8'h42;
    else if (idx == POS_SIG_M)  b = 8'h4d;
    else if (idx < POS_WORDS)   b = '0;
    else if (idx == POS_PLANES) b = 8'd1;
    else if (idx == POS_BPP)    b = 8'(BITS_PER_PIXEL);
    else if (idx >= POS_WEND)   b = '0;
    return b;
  endfunction

endpackage

>>> design/bfs_front.sv
// ----------------------------------------------------------------------------
// bfs_front
// Accepts pixels, tracks column and row, tags header, padding and image end.
// ----------------------------------------------------------------------------
module bfs_front import bfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       pixel_valid,
  output logic       pixel_ready,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_data
);

  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] row_count, row_count_next;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             row_end, image_end;

  assign pixel_ready = !q_full;
  assign q_push      = pixel_valid && pixel_ready;

  assign col_inc   = {1'b0, column_count} + DIM_W'(1);
  assign row_inc   = {1'b0, row_count} + DIM_W'(1);
  assign row_end   = col_inc >= cfg.w;
  assign image_end = row_end && (row_inc >= cfg.h);

  always_comb begin
    q_data.red       = red;
    q_data.green     = green;
    q_data.blue      = blue;
    q_data.hdr       = (column_count == '0) && (row_count == '0);
    q_data.pad       = row_end ? cfg.pad : 2'd0;
    q_data.image_end = image_end;
  end

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (q_push) begin
      if (row_end) begin
        column_count_next = '0;
        row_count_next    = image_end ? '0 : row_inc[CNT_W-1:0];
      end else begin
        column_count_next = col_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

>>> design/bfs_queue.sv
// ----------------------------------------------------------------------------
// bfs_queue
// Two-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bfs_queue import bfs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output entry_t rdata,
  output logic   nonempty
);

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full     = count == QCNT_W'(QDEPTH);
  assign nonempty = count != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign rdata    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH)) else $error("queue count over depth");

  a_push_only_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count did not grow on push");

endmodule

>>> design/bfs_back.sv
// ----------------------------------------------------------------------------
// bfs_back
// Walks one queued pixel's run: optional header, B G R, row padding.
// ----------------------------------------------------------------------------
module bfs_back import bfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       q_nonempty,
  input  entry_t     q_head,
  output logic       q_pop,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       end_of_image
);

  back_state_t      state, state_next;
  entry_t           cur;
  logic [IDX_W-1:0] idx;
  entry_t           sel;
  logic [IDX_W-1:0] sel_idx;
  logic             advance, fire, sel_last;
  logic [7:0]       sel_byte;

  assign advance = !byte_valid || byte_ready;

  always_comb begin
    sel     = cur;
    sel_idx = idx;
    fire    = 1'b0;
    q_pop   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        sel     = q_head;
        sel_idx = q_head.hdr ? POS_SIG_B : POS_BLUE;
        fire    = advance && q_nonempty;
        q_pop   = fire;
      end
      BK_RUN: begin
        fire = advance;
      end
      default: ;
    endcase
  end

  assign sel_last = sel_idx == (POS_RED + IDX_W'(sel.pad));

  always_comb begin
    if (sel_idx < POS_BLUE)        sel_byte = hdr_byte(sel_idx, cfg);
    else if (sel_idx == POS_BLUE)  sel_byte = sel.blue;
    else if (sel_idx == POS_GREEN) sel_byte = sel.green;
    else if (sel_idx == POS_RED)   sel_byte = sel.red;
    else                           sel_byte = '0;
  end

  always_comb begin
    state_next = state;
    if (fire) state_next = sel_last ? BK_IDLE : BK_RUN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      byte_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire)            byte_valid <= 1'b1;
      else if (byte_ready) byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte     <= sel_byte;
      last_of_run  <= sel_last;
      end_of_image <= sel_last && sel.image_end;
      idx          <= sel_idx + IDX_W'(1);
    end
    if (q_pop) cur <= q_head;
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && end_of_image) |-> last_of_run)
    else $error("end_of_image without last_of_run");

  a_run_ends_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && sel_last) |=> state == BK_IDLE)
    else $error("sequencer kept running past the last byte");

  a_pop_from_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == BK_IDLE && q_nonempty && advance))
    else $error("pop outside idle or on empty queue");

endmodule

>>> design/bmp24_file_serializer_unit.sv
// ----------------------------------------------------------------------------
// bmp24_file_serializer_unit
// RGB pixel stream in, uncompressed 24-bit BMP byte stream out.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------
//  pixel    | pixel_valid / pixel_ready  | red, green, blue
//  byte     | byte_valid / byte_ready    | out_byte, last_of_run, end_of_image
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (0 width, 4 height)
//
//  One byte leaves per cycle from the back sequencer while byte_ready is high:
//  a pixel gives 3 bytes, plus the row padding (0..3) on the last pixel of a
//  row and 54 header bytes on the first pixel of an image. A two-word queue
//  lets pixels enter while the sequencer and the output register are busy.
//  Reset returns both dimensions to 1 and the counters to the top of an image.
//  A stalled byte_ready holds the output register, fills the queue, then drops pixel_ready.
// ----------------------------------------------------------------------------
module bmp24_file_serializer_unit import bfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        byte_valid,
  input  logic        byte_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_image
);

  logic [DIM_W-1:0]  image_width, image_height;
  logic [DIM_W-1:0]  w_cl, h_cl;
  logic [DIM_W:0]    row_bytes;
  logic [SIZE_W-1:0] size;
  cfg_t              cfg;
  logic              q_push, q_pop, q_full, q_nonempty;
  entry_t            q_wdata, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(image_height) : 32'(image_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_WIDTH) image_width  <= pwdata[DIM_W-1:0];
      else                       image_height <= pwdata[DIM_W-1:0];
    end
  end

  assign w_cl      = clamp_dim(image_width);
  assign h_cl      = clamp_dim(image_height);
  // bytes per stored row: 3w plus pad, where pad equals w mod 4
  assign row_bytes = {w_cl, 1'b0} + (DIM_W+1)'(w_cl) + (DIM_W+1)'(w_cl[1:0]);

  always_ff @(posedge clk) begin
    size <= SIZE_W'(h_cl) * SIZE_W'(row_bytes) + SIZE_W'(HDR_BYTES);
  end

  always_comb begin
    cfg.w    = w_cl;
    cfg.h    = h_cl;
    cfg.pad  = w_cl[1:0];
    cfg.size = size;
  end

  bfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  bfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_head),
    .nonempty (q_nonempty)
  );

  bfs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .end_of_image (end_of_image)
  );

endmodule
